// ===== rtl/moving_average_filter_core_assert.svh =====
// assertion macros shared by the moving average filter rtl
`ifndef MOVING_AVERAGE_FILTER_CORE_ASSERT_SVH
`define MOVING_AVERAGE_FILTER_CORE_ASSERT_SVH

`ifndef SYNTH

// property checked on every rising clk edge outside reset
`define MAF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define MAF_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define MAF_ASSERT(lbl, prop, msg)
`define MAF_NEVER(lbl, cond, msg)

`endif

`endif

// ===== rtl/maf_pkg.sv =====
`timescale 1ns / 1ps

package maf_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int WS_W           = 7;
    localparam int MAX_WINDOW_DEF = 64;

    localparam logic [WS_W-1:0] WS_RESET = WS_W'(5);

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== rtl/maf_ram.sv =====
`timescale 1ns / 1ps

module maf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/maf_div.sv =====
`timescale 1ns / 1ps

module maf_div
    import maf_pkg::*;
#(
    parameter int SUM_W = 38,
    parameter int DIV_W = WS_W
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [DIV_W-1:0]        divisor,
    output logic signed [SUM_W-1:0] quotient,
    output div_status_t             status
);

    localparam int CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_FIX
    } div_state_t;

    div_state_t         state_reg, state_next;
    logic               neg_reg, neg_next;
    logic [DIV_W:0]     rem_reg, rem_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [SUM_W-1:0]   result_reg, result_next;
    logic [DIV_W:0]     rem_shift;
    logic               fits;

    // one quotient bit per cycle, restoring form
    assign rem_shift = {rem_reg[DIV_W-1:0], quo_reg[SUM_W-1]};
    assign fits      = (rem_shift >= {1'b0, divisor});

    always_comb
    begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    neg_next   = dividend[SUM_W-1];
                    quo_next   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                rem_next = fits ? (rem_shift - {1'b0, divisor}) : rem_shift;
                quo_next = {quo_reg[SUM_W-2:0], fits};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    state_next = D_FIX;
                end
            end
            D_FIX:
            begin
                // truncation toward zero: divide magnitudes, then restore sign
                result_next = neg_reg ? SUM_W'(-quo_reg) : quo_reg;
                done_next   = 1'b1;
                state_next  = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        result_reg <= result_next;
    end

    assign quotient    = signed'(result_reg);
    assign status.busy = (state_reg != D_IDLE);
    assign status.done = done_reg;

endmodule

// ===== rtl/moving_average_filter_core.sv =====
`timescale 1ns / 1ps
// simple moving average filter over signed 32-bit samples
// sample channel: sample_valid / sample_ready carry one sample per transaction
// result channel: result_valid / result_ready carry average and window_filled,
//   exactly one result transaction for every sample transaction
// cfg channel: cfg_valid / cfg_ready write window_size (0 taken as 1, values
//   above MAX_WINDOW clamped); every write restarts the filter
// flow: each sample passes the subtract, add, check, divide and done states,
//   the bit-serial divider making one quotient bit per cycle; samples
//   before the window fills skip the divider
// one sample at a time: sample_ready is high only while idle, so the next
//   sample is taken only after the current one reaches the output register
// reset: count, write slot, sum and current average clear, window_size returns to 5;
//   the sample ring is not cleared, entries are read only after being written
// a stalled receiver holds the result in the output register; the block
//   finishes the next sample and then waits until the register is free
`include "moving_average_filter_core_assert.svh"

module moving_average_filter_core
    import maf_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    output logic                       sample_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic signed [SAMPLE_W-1:0] average,
    output logic                       window_filled,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [WS_W-1:0]            window_size
);

    localparam int WS_MAX   = (1 << WS_W) - 1;
    localparam int WIN_EFF  = (MAX_WINDOW < WS_MAX) ? MAX_WINDOW : WS_MAX;
    localparam int SUM_W    = SAMPLE_W + ((WIN_EFF > 1) ? $clog2(WIN_EFF) : 0);
    localparam int ADDR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CMP_W    = (ADDR_W + 1 > WS_W) ? ADDR_W + 1 : WS_W;
    localparam logic [WS_W-1:0] WIN_LIMIT = WS_W'(WIN_EFF);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_ADD,
        S_CHECK,
        S_DIV,
        S_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [WS_W-1:0]           window_size_reg, window_size_next;
    logic [WS_W-1:0]           samples_seen_reg, samples_seen_next;
    logic [ADDR_W-1:0]         write_slot_reg, write_slot_next;
    logic signed [SUM_W-1:0]   window_sum_reg, window_sum_next;
    logic signed [SAMPLE_W-1:0] current_average_reg, current_average_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                      result_valid_reg, result_valid_next;
    logic signed [SAMPLE_W-1:0] average_reg, average_next;
    logic                      window_filled_reg, window_filled_next;

    logic [WS_W-1:0]           ws_clamped;
    logic [CMP_W-1:0]          slot_plus;
    logic                      filled;
    logic                      ring_we;
    logic [SAMPLE_W-1:0]       ring_rdata;
    logic                      div_start;
    logic signed [SUM_W-1:0]   div_quotient;
    div_status_t               div_stat;

    maf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW),
        .ADDR_W(ADDR_W)
    ) u_ring (
        .clk  (clk),
        .we   (ring_we),
        .waddr(write_slot_reg),
        .wdata(sample_reg),
        .raddr(write_slot_reg),
        .rdata(ring_rdata)
    );

    maf_div #(
        .SUM_W(SUM_W),
        .DIV_W(WS_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(window_sum_reg),
        .divisor (window_size_reg),
        .quotient(div_quotient),
        .status  (div_stat)
    );

    always_comb
    begin
        ws_clamped = window_size;
        if (window_size == '0)
        begin
            ws_clamped = WS_W'(1);
        end
        else if (window_size > WIN_LIMIT)
        begin
            ws_clamped = WIN_LIMIT;
        end
    end

    assign slot_plus    = CMP_W'(write_slot_reg) + CMP_W'(1);
    assign filled       = (samples_seen_reg >= window_size_reg);
    assign cfg_ready    = (state_reg == S_IDLE);
    assign sample_ready = (state_reg == S_IDLE) && !cfg_valid;
    assign ring_we      = (state_reg == S_ADD);
    assign div_start    = (state_reg == S_CHECK) && filled;

    always_comb
    begin
        state_next           = state_reg;
        window_size_next     = window_size_reg;
        samples_seen_next    = samples_seen_reg;
        write_slot_next      = write_slot_reg;
        window_sum_next      = window_sum_reg;
        current_average_next = current_average_reg;
        sample_next          = sample_reg;
        result_valid_next    = result_valid_reg && !result_ready;
        average_next         = average_reg;
        window_filled_next   = window_filled_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    window_size_next     = ws_clamped;
                    samples_seen_next    = '0;
                    write_slot_next      = '0;
                    window_sum_next      = '0;
                    current_average_next = '0;
                end
                else if (sample_valid)
                begin
                    sample_next = sample;
                    state_next  = S_SUB;
                end
            end
            S_SUB:
            begin
                // drop the oldest sample once the window is full
                if (filled)
                begin
                    window_sum_next = window_sum_reg - SUM_W'(signed'(ring_rdata));
                end
                else
                begin
                    samples_seen_next = samples_seen_reg + WS_W'(1);
                end
                state_next = S_ADD;
            end
            S_ADD:
            begin
                window_sum_next = window_sum_reg + SUM_W'(sample_reg);
                if (slot_plus >= CMP_W'(window_size_reg))
                begin
                    write_slot_next = '0;
                end
                else
                begin
                    write_slot_next = slot_plus[ADDR_W-1:0];
                end
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = filled ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    current_average_next = div_quotient[SAMPLE_W-1:0];
                    state_next           = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next  = 1'b1;
                    average_next       = current_average_reg;
                    window_filled_next = filled;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            window_size_reg     <= WS_RESET;
            samples_seen_reg    <= '0;
            write_slot_reg      <= '0;
            window_sum_reg      <= '0;
            current_average_reg <= '0;
            result_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            window_size_reg     <= window_size_next;
            samples_seen_reg    <= samples_seen_next;
            write_slot_reg      <= write_slot_next;
            window_sum_reg      <= window_sum_next;
            current_average_reg <= current_average_next;
            result_valid_reg    <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg        <= sample_next;
        average_reg       <= average_next;
        window_filled_reg <= window_filled_next;
    end

    assign result_valid  = result_valid_reg;
    assign average       = average_reg;
    assign window_filled = window_filled_reg;

    `MAF_NEVER(a_seen_bound, samples_seen_reg > window_size_reg, "sample count above window size")
    `MAF_NEVER(a_slot_bound, CMP_W'(write_slot_reg) >= CMP_W'(window_size_reg), "write slot out of window")
    `MAF_ASSERT(a_div_free, div_start |-> !div_stat.busy, "divider started while busy")
    `MAF_ASSERT(a_div_wait, state_reg == S_DIV |-> (div_stat.busy || div_stat.done), "waiting on idle divider")
    `MAF_ASSERT(a_one_result, (state_reg == S_DONE && state_next == S_IDLE) |=> result_valid, "result lost")

endmodule
